[hdl/sobel_edge_magnitude_defines.svh]
// Assertion macros shared by the Sobel magnitude block.
// No dependencies; taken in by the files that carry assertions.
`ifndef SOBEL_EDGE_MAGNITUDE_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SEM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SEM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/sem_pkg.sv]
// Shared types and constants of the Sobel magnitude block.
// No dependencies.
package sem_pkg;

    localparam int DEF_MAX_WIDTH = 4096;
    localparam int HEIGHT_LIMIT  = 4096;
    localparam int PIX_W         = 8;
    localparam int CFG_W         = 13;
    localparam int ROW_W         = 13;
    localparam int IDX_W         = 2;
    localparam int ABS_W         = 10;
    localparam int SUM_W         = 21;
    localparam int ROOT_W        = 11;
    localparam int STEP_W        = 4;

    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_MAXVAL = 2'd2;

    typedef logic [PIX_W-1:0] pix_t;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_WIN  = 7'b0000010,
        ST_GRAD = 7'b0000100,
        ST_SQX  = 7'b0001000,
        ST_SQY  = 7'b0010000,
        ST_ROOT = 7'b0100000,
        ST_HOLD = 7'b1000000
    } state_t;

    typedef struct packed {
        logic accept;
        logic window;
        logic grad;
        logic sqx;
        logic sqy;
        logic root_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic has_out;
        logic root_done;
        logic out_free;
    } sts_t;

endpackage

[hdl/sobel_edge_magnitude.sv]
// Sobel 3x3 gradient magnitude over a raster pixel stream; top level.
// Depends on sem_pkg, sem_ctrl and sem_datapath.
//
// Takes one 8-bit grey pixel per item in raster order and gives, for every
// image pixel, floor(sqrt(gx^2+gy^2)) clamped to max_value, with the frame
// zero-padded by one pixel on each side. After width*height pixels the host
// sends width+1 flush items for the bottom padding; item n of a frame yields
// the result for raster position n-width-1, and the last result is flagged
// last_of_frame. One item is processed at a time: an item with no result
// goes back to idle after the window update, and an item with a result runs
// through line store read, window update, gradient, two squares through the
// shared multiplier, an 11-bit bitwise square root, one root bit per cycle,
// and the output load, which waits while the output register is full. The next
// item may enter while the previous result waits. Configuration (0 image_width,
// 1 image_height, 2 max_value) is always ready; a width or height write
// restarts the frame. The line stores need no clearing after reset.
module sobel_edge_magnitude #(
    parameter int MAX_WIDTH = sem_pkg::DEF_MAX_WIDTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [sem_pkg::PIX_W-1:0]  s_pixel_value,
    input  logic                       s_flush,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [sem_pkg::PIX_W-1:0]  m_magnitude,
    output logic                       m_last_of_frame,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [sem_pkg::IDX_W-1:0]  cfg_index,
    input  logic [sem_pkg::CFG_W-1:0]  cfg_data
);
    import sem_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // writes are taken at once
    assign cfg_ready = 1'b1;

    sem_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sem_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_pixel_value   (s_pixel_value),
        .s_flush         (s_flush),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_magnitude     (m_magnitude),
        .m_last_of_frame (m_last_of_frame)
    );

endmodule

[hdl/sem_ctrl.sv]
// Sequencer of the Sobel magnitude block: one item at a time.
// Depends on sem_pkg and sobel_edge_magnitude_defines.svh.
`include "sobel_edge_magnitude_defines.svh"
module sem_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sem_pkg::sts_t sts,
    output sem_pkg::cmd_t cmd
);
    import sem_pkg::*;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_WIN;
                end
            end
            ST_WIN: begin
                cmd.window = 1'b1;
                state_next = sts.has_out ? ST_GRAD : ST_IDLE;
            end
            ST_GRAD: begin
                cmd.grad   = 1'b1;
                state_next = ST_SQX;
            end
            ST_SQX: begin
                cmd.sqx    = 1'b1;
                state_next = ST_SQY;
            end
            ST_SQY: begin
                cmd.sqy    = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                if (sts.root_done) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `SEM_ASSERT_NEXT(a_accept_to_win, aclk, aresetn, s_valid && s_ready,
        state_reg == ST_WIN, "accepted item did not enter window update")
    `SEM_ASSERT_NEXT(a_no_out_idle, aclk, aresetn, (state_reg == ST_WIN) && !sts.has_out,
        state_reg == ST_IDLE, "item without result did not return to idle")
    `SEM_ASSERT_NEXT(a_root_to_hold, aclk, aresetn, (state_reg == ST_ROOT) && sts.root_done,
        state_reg == ST_HOLD, "finished root did not move to output")

endmodule

[hdl/sem_datapath.sv]
// Datapath: line stores, window, gradient, shared multiplier and bitwise square root.
// Depends on sem_pkg and sobel_edge_magnitude_defines.svh.
`include "sobel_edge_magnitude_defines.svh"
module sem_datapath #(
    parameter int MAX_WIDTH = sem_pkg::DEF_MAX_WIDTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sem_pkg::cmd_t               cmd,
    output sem_pkg::sts_t               sts,
    input  logic [sem_pkg::PIX_W-1:0]   s_pixel_value,
    input  logic                        s_flush,
    input  logic                        cfg_we,
    input  logic [sem_pkg::IDX_W-1:0]   cfg_index,
    input  logic [sem_pkg::CFG_W-1:0]   cfg_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [sem_pkg::PIX_W-1:0]   m_magnitude,
    output logic                        m_last_of_frame
);
    import sem_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    // configuration
    logic [CFG_W-1:0] width_reg, height_reg;
    pix_t             maxval_reg;
    logic [WW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = ROW_W'(1);
        end else if (32'(height_reg) > HEIGHT_LIMIT) begin
            h_eff = ROW_W'(HEIGHT_LIMIT);
        end else begin
            h_eff = ROW_W'(height_reg);
        end
    end

    logic restart;
    assign restart = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_W'(640);
            height_reg <= CFG_W'(480);
            maxval_reg <= 8'd255;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_MAXVAL: maxval_reg <= cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // position, line stores
    logic [AW-1:0]    col_reg, addr_reg, c_eff;
    logic [ROW_W-1:0] row_reg;
    pix_t             pix_reg, upper_q, middle_q;
    pix_t             line_upper [MAX_WIDTH];
    pix_t             line_middle[MAX_WIDTH];

    assign c_eff = (32'(col_reg) >= 32'(w_eff)) ? '0 : col_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            upper_q  <= line_upper[c_eff];
            middle_q <= line_middle[c_eff];
            addr_reg <= c_eff;
            pix_reg  <= (s_flush || row_reg >= h_eff) ? '0 : s_pixel_value;
        end
        if (cmd.window) begin
            line_upper[addr_reg]  <= (row_reg >= ROW_W'(1)) ? middle_q : '0;
            line_middle[addr_reg] <= pix_reg;
        end
    end

    pix_t top_pix, mid_pix;
    logic c_zero, edge_out, full_out;
    assign top_pix  = (row_reg >= ROW_W'(2)) ? upper_q : '0;
    assign mid_pix  = (row_reg >= ROW_W'(1)) ? middle_q : '0;
    assign c_zero   = (addr_reg == '0);
    assign edge_out = c_zero && row_reg >= ROW_W'(2) && row_reg <= h_eff + ROW_W'(1);
    assign full_out = !c_zero && row_reg >= ROW_W'(1) && row_reg <= h_eff;
    assign sts.has_out = edge_out || full_out;

    // window keeps its two right columns; col 0 of the full window is the old col 1
    pix_t win1_reg[3], win2_reg[3];
    pix_t opl_reg[3], opm_reg[3], opr_reg[3];
    logic last_reg;
    logic [31:0] col_inc;
    assign col_inc = 32'(addr_reg) + 32'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            col_reg <= '0;
            row_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                win1_reg[i] <= '0;
                win2_reg[i] <= '0;
            end
        end else if (cmd.window) begin
            for (int i = 0; i < 3; i++) begin
                opl_reg[i] <= win1_reg[i];
                opm_reg[i] <= win2_reg[i];
            end
            opr_reg[0] <= c_zero ? '0 : top_pix;
            opr_reg[1] <= c_zero ? '0 : mid_pix;
            opr_reg[2] <= c_zero ? '0 : pix_reg;
            last_reg   <= c_zero && (row_reg == h_eff + ROW_W'(1));
            if (row_reg >= h_eff + ROW_W'(1)) begin
                col_reg <= '0;
                row_reg <= '0;
                for (int i = 0; i < 3; i++) begin
                    win1_reg[i] <= '0;
                    win2_reg[i] <= '0;
                end
            end else begin
                win1_reg[0] <= c_zero ? '0 : win2_reg[0];
                win1_reg[1] <= c_zero ? '0 : win2_reg[1];
                win1_reg[2] <= c_zero ? '0 : win2_reg[2];
                win2_reg[0] <= top_pix;
                win2_reg[1] <= mid_pix;
                win2_reg[2] <= pix_reg;
                if (col_inc >= 32'(w_eff)) begin
                    col_reg <= '0;
                    row_reg <= row_reg + ROW_W'(1);
                end else begin
                    col_reg <= AW'(col_inc);
                end
            end
        end
    end

    // gradient
    logic [9:0]  lsum, rsum, tsum, bsum;
    logic [11:0] gx, gy;
    logic [ABS_W-1:0] ax_reg, ay_reg;
    assign lsum = 10'(opl_reg[0]) + {opl_reg[1], 1'b0} + 10'(opl_reg[2]);
    assign rsum = 10'(opr_reg[0]) + {opr_reg[1], 1'b0} + 10'(opr_reg[2]);
    assign tsum = 10'(opl_reg[0]) + {opm_reg[0], 1'b0} + 10'(opr_reg[0]);
    assign bsum = 10'(opl_reg[2]) + {opm_reg[2], 1'b0} + 10'(opr_reg[2]);
    assign gx   = {2'b00, rsum} - {2'b00, lsum};
    assign gy   = {2'b00, bsum} - {2'b00, tsum};

    // one multiplier serves both squares and the root trials
    logic [ROOT_W-1:0]   mul_a;
    logic [2*ROOT_W-1:0] mul_p;
    logic [SUM_W-1:0]    sq_reg, sum_reg;
    logic [ROOT_W-1:0]   root_reg, trial;
    logic [STEP_W-1:0]   step_reg;

    assign trial = root_reg | (ROOT_W'(1) << step_reg);
    always_comb begin
        if (cmd.sqx) begin
            mul_a = ROOT_W'(ax_reg);
        end else if (cmd.sqy) begin
            mul_a = ROOT_W'(ay_reg);
        end else begin
            mul_a = trial;
        end
    end
    assign mul_p = mul_a * mul_a;
    assign sts.root_done = (step_reg == '0);

    always_ff @(posedge aclk) begin
        if (cmd.grad) begin
            ax_reg <= gx[11] ? ABS_W'(-gx) : gx[ABS_W-1:0];
            ay_reg <= gy[11] ? ABS_W'(-gy) : gy[ABS_W-1:0];
        end
        if (cmd.sqx) begin
            sq_reg <= SUM_W'(mul_p);
        end
        if (cmd.sqy) begin
            sum_reg  <= sq_reg + SUM_W'(mul_p);
            root_reg <= '0;
            step_reg <= STEP_W'(ROOT_W - 1);
        end
        if (cmd.root_step) begin
            if (mul_p <= 22'(sum_reg)) begin
                root_reg <= trial;
            end
            if (step_reg != '0) begin
                step_reg <= step_reg - STEP_W'(1);
            end
        end
    end

    // output register
    logic m_valid_reg, m_last_reg;
    pix_t m_mag_reg;
    assign sts.out_free    = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_magnitude     = m_mag_reg;
    assign m_last_of_frame = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.load_out) begin
            m_mag_reg  <= (root_reg > ROOT_W'(maxval_reg)) ? maxval_reg : root_reg[PIX_W-1:0];
            m_last_reg <= last_reg;
        end
    end

    `SEM_ASSERT_NOW(a_load_free, aclk, aresetn, cmd.load_out,
        !m_valid_reg || m_ready, "result loaded over an untaken one")
    `SEM_ASSERT_NOW(a_row_bound, aclk, aresetn, 1'b1,
        row_reg <= h_eff + ROW_W'(1), "row counter past bottom padding")
    `SEM_ASSERT_NOW(a_root_exact, aclk, aresetn, cmd.load_out,
        (24'(root_reg) * 24'(root_reg) <= 24'(sum_reg)) &&
        ((24'(root_reg) + 24'd1) * (24'(root_reg) + 24'd1) > 24'(sum_reg)),
        "square root not exact floor")

endmodule

[verif/sobel_edge_magnitude_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for sobel_edge_magnitude: frames of pixels and flushes
// are driven over valid/ready and every result is checked against an
// in-bench Sobel magnitude predictor. Depends on sem_pkg and the block's RTL.
module sobel_edge_magnitude_test;
    import sem_pkg::*;

    localparam int CYCLE_LIMIT = 6000000;
    localparam int SETTLE = 40;   // a result-free item can still be in flight

    typedef struct {
        logic [7:0] mag;
        logic       last;
    } edge_px_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [PIX_W-1:0] s_pixel_value = '0;
    logic s_flush = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [PIX_W-1:0] m_magnitude;
    logic m_last_of_frame;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    sobel_edge_magnitude dut (.*);

    // Predictor state: a copy of what the block holds.
    logic [7:0]  upper_line [DEF_MAX_WIDTH];
    logic [7:0]  middle_line [DEF_MAX_WIDTH];
    logic [7:0]  win [3][3];   // [row top..bottom][col left..right]
    int unsigned col_pos, row_pos;
    int unsigned img_w, img_h, clamp_max;

    edge_px_t    pending_px[$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          frames_done = 0;
    longint      cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("sobel_edge_magnitude: mismatch");
            $finish;
        end
    end

    function automatic int unsigned isqrt(int unsigned s);
        int unsigned root;
        int unsigned t;
        root = 0;
        for (int b = 11; b >= 0; b--) begin
            t = root | (1 << b);
            if (t * t <= s) root = t;
        end
        return root;
    endfunction

    // Columns l, m, r are top to bottom.
    function automatic logic [7:0] sobel_mag(int l0, int l1, int l2, int m0, int m2,
                                             int r0, int r1, int r2);
        int gx, gy;
        int unsigned m;
        gx = (r0 + 2 * r1 + r2) - (l0 + 2 * l1 + l2);
        gy = (l2 + 2 * m2 + r2) - (l0 + 2 * m0 + r0);
        m = isqrt(gx * gx + gy * gy);
        return (m > clamp_max) ? clamp_max[7:0] : m[7:0];
    endfunction

    function automatic void restart_frame();
        foreach (win[i, j]) win[i][j] = '0;
        col_pos = 0;
        row_pos = 0;
    endfunction

    // Advance the predictor by one accepted item; queue any result.
    function automatic void predict_item(logic [7:0] pix, logic fl);
        int unsigned w, h, c, r;
        logic [7:0] v, top, mid;
        edge_px_t px;
        w = (img_w < 1) ? 1 : (img_w > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : img_w);
        h = (img_h < 1) ? 1 : (img_h > HEIGHT_LIMIT ? HEIGHT_LIMIT : img_h);
        c = (col_pos >= w) ? 0 : col_pos;
        r = row_pos;
        v = (fl || r >= h) ? 8'd0 : pix;
        top = (r >= 2) ? upper_line[c] : 8'd0;
        mid = (r >= 1) ? middle_line[c] : 8'd0;
        if (c == 0) begin
            // right edge of row r-2 closes with zero padding
            if (r >= 2 && r <= h + 1) begin
                px.mag = sobel_mag(win[0][1], win[1][1], win[2][1], win[0][2], win[2][2],
                                   0, 0, 0);
                px.last = (r == h + 1);
                pending_px.push_back(px);
            end
            for (int i = 0; i < 3; i++) begin
                win[i][0] = '0;
                win[i][1] = '0;
            end
        end else begin
            for (int i = 0; i < 3; i++) begin
                win[i][0] = win[i][1];
                win[i][1] = win[i][2];
            end
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = v;
        upper_line[c] = mid;
        middle_line[c] = v;
        if (c >= 1 && r >= 1 && r <= h) begin
            px.mag = sobel_mag(win[0][0], win[1][0], win[2][0], win[0][1], win[2][1],
                               win[0][2], win[1][2], win[2][2]);
            px.last = 1'b0;
            pending_px.push_back(px);
        end
        if (r >= h + 1) begin
            restart_frame();
            frames_done++;
        end else begin
            c++;
            if (c >= w) begin
                c = 0;
                r++;
            end
            col_pos = c;
            row_pos = r;
        end
    endfunction

    // Result side: check, then pick next ready (long hold-off wins).
    always @(posedge aclk) begin
        edge_px_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_px.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result mag=%0d last=%0b", m_magnitude,
                             m_last_of_frame);
            end else begin
                want = pending_px.pop_front();
                if (want.mag !== m_magnitude || want.last !== m_last_of_frame) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected mag=%0d last=%0b, got mag=%0d last=%0b",
                                 results_seen, want.mag, want.last, m_magnitude,
                                 m_last_of_frame);
                end
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_item(logic [7:0] pix, logic fl);
        if (send_idle_pct > 0) begin
            while ($urandom_range(99) < send_idle_pct) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_pixel_value <= pix;
        s_flush <= fl;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_item(pix, fl);
        items_sent++;
    endtask

    task automatic drop_valid();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Quiet point for register writes: results drained, block settled.
    task automatic drain();
        drop_valid();
        while (pending_px.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_W-1:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_WIDTH:  begin img_w = val & 32'h1FFF; restart_frame(); end
            REG_HEIGHT: begin img_h = val & 32'h1FFF; restart_frame(); end
            REG_MAXVAL: clamp_max = val & 8'hFF;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_frame(int unsigned w, int unsigned h, int unsigned mx);
        drain();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_MAXVAL, mx);
    endtask

    // kind 0: random pixels, 1: 0/255 checkerboard, 2: random with stray
    // flushes inside the frame and live pixels in the padding rows.
    task automatic send_frame(int kind);
        int n;
        logic [7:0] p;
        logic fl;
        n = img_w * img_h;
        for (int k = 0; k < n + img_w + 1; k++) begin
            if (k < n) begin
                p = (kind == 1) ? (((k % img_w + k / img_w) % 2) ? 8'hFF : 8'h00)
                                : 8'($urandom);
                fl = (kind == 2) && ($urandom_range(9) == 0);
            end else begin
                p = 8'($urandom);
                fl = !((kind == 2) && $urandom_range(3) == 0);
            end
            send_item(p, fl);
        end
    endtask

    task automatic test_tiny_frames();
        set_frame(1, 1, 255);
        send_frame(0);
        set_frame(3, 3, 255);
        send_frame(1);
        set_frame(2, 2, 1);
        send_frame(1);
    endtask

    task automatic test_irregular_items();
        set_frame(4, 3, 200);
        send_frame(2);
        send_frame(2);
    endtask

    // Width/height write mid-frame throws the partial frame away.
    task automatic test_abandoned_frame();
        set_frame(5, 4, 255);
        for (int k = 0; k < 9; k++) send_item(8'($urandom), 1'b0);
        drain();
        write_reg(REG_HEIGHT, 3);
        send_frame(0);
        for (int k = 0; k < 4; k++) send_item(8'($urandom), 1'b0);
        drain();
        write_reg(REG_WIDTH, 3);
        send_frame(0);
    endtask

    task automatic test_large_sizes();
        set_frame(120, 1, 255);
        send_frame(0);
        set_frame(1, 150, 255);
        send_frame(1);
    endtask

    // Receiver holds off long enough that the output register fills and
    // s_ready drops while items keep being offered.
    task automatic test_backpressure();
        set_frame(20, 5, 255);
        hold_cycles = 400;
        send_frame(0);
        drain();
        send_frame(0);
    endtask

    task automatic test_random();
        int stop_at;
        int pct_s[4] = '{0, 61, 0, 17};
        int pct_r[4] = '{0, 0, 61, 17};
        for (int ph = 0; ph < 4; ph++) begin
            stop_at = items_sent + 150;
            while (items_sent < stop_at) begin
                set_frame($urandom_range(1, 12), $urandom_range(1, 8),
                          ($urandom_range(3) == 0) ? $urandom_range(1, 255) : 255);
                send_idle_pct = pct_s[ph];
                recv_stall_pct = pct_r[ph];
                send_frame(($urandom_range(4) == 0) ? 2 : 0);
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
        end
    endtask

    initial begin
        img_w = 640;
        img_h = 480;
        clamp_max = 255;
        foreach (upper_line[i]) begin
            upper_line[i] = '0;
            middle_line[i] = '0;
        end
        restart_frame();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_tiny_frames();
        test_irregular_items();
        test_abandoned_frame();
        test_large_sizes();
        test_backpressure();
        test_random();

        drain();
        $display("covered %0d items, %0d results, %0d whole frames", items_sent,
                 results_seen, frames_done);
        $display("sizes 1x1 up to 120 wide and 150 high, clamps 1..255, stalls, resizes");
        if (mismatches == 0 && pending_px.size() == 0) begin
            $display("sobel_edge_magnitude: match");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, pending_px.size());
            $display("sobel_edge_magnitude: mismatch");
        end
        $finish;
    end
endmodule
